/* rtl/bfrc_pkg.sv */
// ----------------------------------------------------------------------------
// bfrc_pkg
// Shared types and constants of the bridge frame receive checker.
// ----------------------------------------------------------------------------
package bfrc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 250;
    localparam int MAGIC_BYTES         = 2;
    localparam int HEAD_BYTES          = 4;
    localparam int TIME_FRAME_BYTES    = 8;

    localparam logic [15:0] PACKET_MAGIC   = 16'hC03E;
    localparam logic [15:0] TIME_MAGIC     = 16'hC03F;
    localparam logic [31:0] TIME_FLOOR_RST = 32'd1700000000;
    localparam logic [31:0] COOLDOWN_RST   = 32'd43200000;
    localparam logic [8:0]  SUM_MOD        = 9'd255;

    localparam int ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_KEY_LOW    = 3'd0,
        REG_KEY_HIGH   = 3'd1,
        REG_KEY_LENGTH = 3'd2,
        REG_TIME_FLOOR = 3'd3,
        REG_COOLDOWN   = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SUM_BAD     = 4'd1,
        ST_SHORT       = 4'd2,
        ST_LONG        = 4'd3,
        ST_MAGIC       = 4'd4,
        ST_NO_KEY      = 4'd5,
        ST_TIME_OK     = 4'd6,
        ST_TIME_LEN    = 4'd7,
        ST_IMPLAUSIBLE = 4'd8,
        ST_COOLDOWN    = 4'd9
    } t_status;

    typedef struct packed {
        logic [63:0] key_low;
        logic [55:0] key_high;
        logic [3:0]  key_length;
        logic [31:0] time_floor;
        logic [31:0] cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_end;
        t_status     status;
        logic [31:0] time_value;
    } t_result;

endpackage

/* rtl/bfrc_regs.sv */
// ----------------------------------------------------------------------------
// bfrc_regs
// Configuration registers behind a 64-bit APB-style port.
// ----------------------------------------------------------------------------
module bfrc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bfrc_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output bfrc_pkg::t_cfg             o_cfg
);

    bfrc_pkg::t_cfg   r_cfg;
    bfrc_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = bfrc_pkg::t_reg_idx'(paddr[bfrc_pkg::ADDR_W-1:3]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_low     <= '0;
            r_cfg.key_high    <= '0;
            r_cfg.key_length  <= '0;
            r_cfg.time_floor  <= bfrc_pkg::TIME_FLOOR_RST;
            r_cfg.cooldown_ms <= bfrc_pkg::COOLDOWN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bfrc_pkg::REG_KEY_LOW:    r_cfg.key_low     <= pwdata;
                bfrc_pkg::REG_KEY_HIGH:   r_cfg.key_high    <= pwdata[55:0];
                bfrc_pkg::REG_KEY_LENGTH: r_cfg.key_length  <= pwdata[3:0];
                bfrc_pkg::REG_TIME_FLOOR: r_cfg.time_floor  <= pwdata[31:0];
                bfrc_pkg::REG_COOLDOWN:   r_cfg.cooldown_ms <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bfrc_pkg::REG_KEY_LOW:    prdata = r_cfg.key_low;
            bfrc_pkg::REG_KEY_HIGH:   prdata = {8'h00, r_cfg.key_high};
            bfrc_pkg::REG_KEY_LENGTH: prdata = {60'd0, r_cfg.key_length};
            bfrc_pkg::REG_TIME_FLOOR: prdata = {32'd0, r_cfg.time_floor};
            bfrc_pkg::REG_COOLDOWN:   prdata = {32'd0, r_cfg.cooldown_ms};
            default:                  prdata = '0;
        endcase
    end

endmodule

/* rtl/bridge_frame_receive_checker.sv */
// ----------------------------------------------------------------------------
// bridge_frame_receive_checker
// Checks received frames byte by byte: length, magic, XOR key decryption,
// Fletcher-16 check and time-beacon acceptance; streams packet payload.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  i_rx_byte, i_frame_last, i_now_ms
//   output    out        o_valid / i_stall  o_payload_byte, o_byte_valid,
//                                           o_frame_end, o_status, o_time_value
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// one request per cycle while o_stall is low; a result is registered when its byte is taken
// decryption, checksum and status are worked out in the accept cycle and
// land in a two-entry output buffer (output register plus skid register)
// o_stall rises only while the skid register holds a result
// synchronous reset clears frame state, beacon history and the buffer
// ----------------------------------------------------------------------------
module bridge_frame_receive_checker #(
    parameter int MAX_FRAME_BYTES = bfrc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_frame_last,
    input  logic [31:0]                 i_now_ms,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_payload_byte,
    output logic                        o_byte_valid,
    output logic                        o_frame_end,
    output logic [3:0]                  o_status,
    output logic [31:0]                 o_time_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfrc_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [PW-1:0] POS_MAGIC = PW'(bfrc_pkg::MAGIC_BYTES);
    localparam logic [PW-1:0] POS_HEAD  = PW'(bfrc_pkg::HEAD_BYTES);
    localparam logic [PW-1:0] POS_TIME  = PW'(bfrc_pkg::TIME_FRAME_BYTES);
    localparam logic [PW-1:0] POS_MAX   = PW'(MAX_FRAME_BYTES);
    localparam logic [PW-1:0] POS_SAT   = PW'(MAX_FRAME_BYTES + 1);

    bfrc_pkg::t_cfg cfg;

    bfrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame state
    logic [PW-1:0] r_pos,        n_pos;
    logic [15:0]   r_magic,      n_magic;
    logic [3:0]    r_key_index,  n_key_index;
    logic [7:0]    r_sum_low,    n_sum_low;
    logic [7:0]    r_sum_high,   n_sum_high;
    logic [15:0]   r_check,      n_check;
    logic [31:0]   r_time,       n_time;
    logic [31:0]   r_last_applied, n_last_applied;
    logic          r_ever,       n_ever;

    // output buffer
    bfrc_pkg::t_result r_out,  r_skid;
    logic              r_out_valid, r_skid_valid;

    logic              in_acc;
    logic              out_take;
    logic              has_result;
    bfrc_pkg::t_result res;

    logic [127:0]  key_all;
    logic [3:0]    k_cur;
    logic [3:0]    k_inc;
    logic [7:0]    key_byte;
    logic [7:0]    dec;
    logic [8:0]    low_sum;
    logic [8:0]    high_sum;
    logic [PW-1:0] count;
    logic          decrypt_en;
    logic          pay_valid;
    logic          sum_ok;
    logic          cooling;
    logic [31:0]   elapsed;
    bfrc_pkg::t_status st;

    assign in_acc   = i_valid & ~r_skid_valid;
    assign out_take = r_out_valid & ~i_stall;
    assign o_stall  = r_skid_valid;

    assign key_all  = {8'h00, cfg.key_high, cfg.key_low};
    assign k_cur    = (r_key_index >= cfg.key_length) ? 4'd0 : r_key_index;
    assign k_inc    = k_cur + 4'd1;
    assign key_byte = key_all[{k_cur, 3'b000} +: 8];
    assign dec      = i_rx_byte ^ key_byte;
    assign low_sum  = {1'b0, r_sum_low} + {1'b0, dec};
    assign elapsed  = i_now_ms - r_last_applied;
    assign count    = (r_pos == POS_SAT) ? r_pos : r_pos + PW'(1);

    assign decrypt_en = (r_pos >= POS_MAGIC) && (r_pos < POS_MAX) &&
                        (cfg.key_length != 4'd0);

    always_comb begin
        n_magic     = r_magic;
        n_key_index = r_key_index;
        n_sum_low   = r_sum_low;
        n_sum_high  = r_sum_high;
        n_check     = r_check;
        n_time      = r_time;
        pay_valid   = 1'b0;
        high_sum    = '0;
        if (r_pos < POS_MAGIC) begin
            n_magic = {r_magic[7:0], i_rx_byte};
        end else if (decrypt_en) begin
            n_key_index = (k_inc >= cfg.key_length) ? 4'd0 : k_inc;
            if (r_pos < POS_HEAD) begin
                n_check = {r_check[7:0], dec};
            end else begin
                n_sum_low  = (low_sum >= bfrc_pkg::SUM_MOD) ?
                             8'(low_sum - bfrc_pkg::SUM_MOD) : low_sum[7:0];
                high_sum   = {1'b0, r_sum_high} + {1'b0, n_sum_low};
                n_sum_high = (high_sum >= bfrc_pkg::SUM_MOD) ?
                             8'(high_sum - bfrc_pkg::SUM_MOD) : high_sum[7:0];
                n_time     = {r_time[23:0], dec};
                pay_valid  = (r_magic == bfrc_pkg::PACKET_MAGIC);
            end
        end
    end

    assign sum_ok  = ({n_sum_high, n_sum_low} == n_check);
    assign cooling = r_ever && (elapsed < cfg.cooldown_ms);

    always_comb begin
        if (count < POS_HEAD) begin
            st = bfrc_pkg::ST_SHORT;
        end else if (count > POS_MAX) begin
            st = bfrc_pkg::ST_LONG;
        end else if (n_magic == bfrc_pkg::TIME_MAGIC) begin
            if (count != POS_TIME) begin
                st = bfrc_pkg::ST_TIME_LEN;
            end else if (cfg.key_length == 4'd0) begin
                st = bfrc_pkg::ST_NO_KEY;
            end else if (!sum_ok) begin
                st = bfrc_pkg::ST_SUM_BAD;
            end else if (n_time < cfg.time_floor) begin
                st = bfrc_pkg::ST_IMPLAUSIBLE;
            end else if (cooling) begin
                st = bfrc_pkg::ST_COOLDOWN;
            end else begin
                st = bfrc_pkg::ST_TIME_OK;
            end
        end else if (n_magic != bfrc_pkg::PACKET_MAGIC) begin
            st = bfrc_pkg::ST_MAGIC;
        end else if (cfg.key_length == 4'd0) begin
            st = bfrc_pkg::ST_NO_KEY;
        end else begin
            st = sum_ok ? bfrc_pkg::ST_OK : bfrc_pkg::ST_SUM_BAD;
        end
    end

    always_comb begin
        has_result       = pay_valid | i_frame_last;
        res.payload_byte = pay_valid ? dec : 8'd0;
        res.byte_valid   = pay_valid;
        res.frame_end    = i_frame_last;
        res.status       = i_frame_last ? st : bfrc_pkg::ST_OK;
        res.time_value   = (i_frame_last && st == bfrc_pkg::ST_TIME_OK) ? n_time : 32'd0;
        n_pos            = i_frame_last ? '0 : count;
        n_last_applied   = r_last_applied;
        n_ever           = r_ever;
        if (i_frame_last && st == bfrc_pkg::ST_TIME_OK) begin
            n_last_applied = i_now_ms;
            n_ever         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_magic        <= '0;
            r_key_index    <= '0;
            r_sum_low      <= '0;
            r_sum_high     <= '0;
            r_check        <= '0;
            r_time         <= '0;
            r_last_applied <= '0;
            r_ever         <= 1'b0;
        end else if (in_acc) begin
            r_pos          <= n_pos;
            r_last_applied <= n_last_applied;
            r_ever         <= n_ever;
            if (i_frame_last) begin
                r_magic     <= '0;
                r_key_index <= '0;
                r_sum_low   <= '0;
                r_sum_high  <= '0;
                r_check     <= '0;
                r_time      <= '0;
            end else begin
                r_magic     <= n_magic;
                r_key_index <= n_key_index;
                r_sum_low   <= n_sum_low;
                r_sum_high  <= n_sum_high;
                r_check     <= n_check;
                r_time      <= n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && has_result) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc && has_result) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_valid   = r_out.byte_valid;
    assign o_frame_end    = r_out.frame_end;
    assign o_status       = r_out.status;
    assign o_time_value   = r_out.time_value;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte position beyond saturation");

    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_end) |-> (o_status == bfrc_pkg::ST_OK && o_byte_valid))
        else $error("mid-frame result without payload or with status");

    a_time_only_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bfrc_pkg::ST_TIME_OK) |-> (o_time_value == 32'd0))
        else $error("time value without applied beacon");

    a_ever_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ever |=> r_ever)
        else $error("beacon history lost");

endmodule

/* dv/bridge_frame_receive_checker_tb.sv */
// ----------------------------------------------------------------------------
// bridge_frame_receive_checker_tb
// Self-checking bench for the frame receive checker. Directed frames cover
// length, magic, key, checksum and time beacon rules. Random frame traffic
// follows under random idling and backpressure. Every result is compared in
// order with a predictor that tracks the frame state one request at a time.
// ----------------------------------------------------------------------------
module bridge_frame_receive_checker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_BYTES = 610;
    localparam int QUIET_AFTER  = 500;
    localparam int DRAIN_CYCLES = 4;
    localparam int SAT_COUNT    = bfrc_pkg::MAX_FRAME_BYTES_DEF + 1;

    typedef logic [7:0] t_octets[$];

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [7:0]                  i_rx_byte;
    logic                        i_frame_last;
    logic [31:0]                 i_now_ms;
    logic                        o_valid;
    logic                        i_stall;
    logic [7:0]                  o_payload_byte;
    logic                        o_byte_valid;
    logic                        o_frame_end;
    logic [3:0]                  o_status;
    logic [31:0]                 o_time_value;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bfrc_pkg::ADDR_W-1:0] paddr;
    logic [63:0]                 pwdata;
    logic [63:0]                 prdata;
    logic                        pready;

    bfrc_pkg::t_cfg    cfg;
    int                frm_pos;
    logic [15:0]       frm_magic;
    int                frm_key_idx;
    logic [7:0]        sum_lo;
    logic [7:0]        sum_hi;
    logic [15:0]       rx_check;
    logic [31:0]       time_acc;
    logic [31:0]       last_applied;
    bit                applied_once;
    bfrc_pkg::t_result result_q[$];

    int          errors;
    int          cycle_count;
    bit          src_idle_en;
    bit          sink_idle_en;
    int          hold_req;
    int          hold_left;
    int          burst_left;
    logic [31:0] wall_ms;

    bridge_frame_receive_checker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_last   (i_frame_last),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_valid   (o_byte_valid),
        .o_frame_end    (o_frame_end),
        .o_status       (o_status),
        .o_time_value   (o_time_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** bridge_frame_receive_checker: FAILED **");
        $finish;
    end

    // receiver stall: random bursts plus long hold-offs on request
    initial begin
        i_stall <= 1'b0;
        hold_left = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] key_at(input int k);
        if (k < 8) return cfg.key_low[8*k +: 8];
        return cfg.key_high[8*(k-8) +: 8];
    endfunction

    function automatic void clear_frame();
        frm_pos = 0;
        frm_magic = '0;
        frm_key_idx = 0;
        sum_lo = '0;
        sum_hi = '0;
        rx_check = '0;
        time_acc = '0;
    endfunction

    function automatic bfrc_pkg::t_status frame_verdict(input int count,
                                                         input logic [31:0] now);
        logic [31:0] elapsed;
        logic        sum_ok;
        elapsed = now - last_applied;
        sum_ok = ({sum_hi, sum_lo} == rx_check);
        if (count < bfrc_pkg::HEAD_BYTES) return bfrc_pkg::ST_SHORT;
        if (count > bfrc_pkg::MAX_FRAME_BYTES_DEF) return bfrc_pkg::ST_LONG;
        if (frm_magic == bfrc_pkg::TIME_MAGIC) begin
            if (count != bfrc_pkg::TIME_FRAME_BYTES) return bfrc_pkg::ST_TIME_LEN;
            if (cfg.key_length == 0) return bfrc_pkg::ST_NO_KEY;
            if (!sum_ok) return bfrc_pkg::ST_SUM_BAD;
            if (time_acc < cfg.time_floor) return bfrc_pkg::ST_IMPLAUSIBLE;
            if (applied_once && elapsed < cfg.cooldown_ms) return bfrc_pkg::ST_COOLDOWN;
            last_applied = now;
            applied_once = 1'b1;
            return bfrc_pkg::ST_TIME_OK;
        end
        if (frm_magic != bfrc_pkg::PACKET_MAGIC) return bfrc_pkg::ST_MAGIC;
        if (cfg.key_length == 0) return bfrc_pkg::ST_NO_KEY;
        return sum_ok ? bfrc_pkg::ST_OK : bfrc_pkg::ST_SUM_BAD;
    endfunction

    task automatic predict_request(input logic [7:0] b, input logic is_last,
                                   input logic [31:0] now);
        int                k;
        int                count;
        logic [7:0]        d;
        bfrc_pkg::t_result r;
        r = '0;
        if (frm_pos < bfrc_pkg::MAGIC_BYTES) begin
            frm_magic = {frm_magic[7:0], b};
        end else if (frm_pos < bfrc_pkg::MAX_FRAME_BYTES_DEF && cfg.key_length != 0) begin
            k = frm_key_idx;
            if (k >= cfg.key_length) k = 0;
            d = b ^ key_at(k);
            k++;
            frm_key_idx = (k >= cfg.key_length) ? 0 : k;
            if (frm_pos < bfrc_pkg::HEAD_BYTES) begin
                rx_check = {rx_check[7:0], d};
            end else begin
                sum_lo = (sum_lo + d) % bfrc_pkg::SUM_MOD;
                sum_hi = (sum_hi + sum_lo) % bfrc_pkg::SUM_MOD;
                time_acc = {time_acc[23:0], d};
                if (frm_magic == bfrc_pkg::PACKET_MAGIC) begin
                    r.byte_valid = 1'b1;
                    r.payload_byte = d;
                end
            end
        end
        count = (frm_pos + 1 > SAT_COUNT) ? SAT_COUNT : frm_pos + 1;
        frm_pos = count;
        if (is_last) begin
            r.frame_end = 1'b1;
            r.status = frame_verdict(count, now);
            if (r.status == bfrc_pkg::ST_TIME_OK) r.time_value = time_acc;
            clear_frame();
        end
        if (r.byte_valid || is_last) result_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        bfrc_pkg::t_result want;
        if (result_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual byte %0h valid %0b",
                     $time, o_payload_byte, o_byte_valid);
            $display("%0t:   end %0b status %0d time %0h",
                     $time, o_frame_end, o_status, o_time_value);
        end else begin
            want = result_q.pop_front();
            check_field("payload_byte", want.payload_byte, o_payload_byte);
            check_field("byte_valid", want.byte_valid, o_byte_valid);
            check_field("frame_end", want.frame_end, o_frame_end);
            check_field("status", want.status, o_status);
            check_field("time_value", want.time_value, o_time_value);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) predict_request(i_rx_byte, i_frame_last, i_now_ms);
        if (i_rst_n && o_valid && !i_stall) check_result();
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last, input logic [31:0] now);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        i_frame_last <= is_last;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_frame(input t_octets f, input logic [31:0] now_end);
        foreach (f[i]) begin
            if (i == f.size() - 1) send_byte(f[i], 1'b1, now_end);
            else send_byte(f[i], 1'b0, $urandom);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bfrc_pkg::t_reg_idx idx, input logic [63:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bfrc_pkg::REG_KEY_LOW:    cfg.key_low = value;
            bfrc_pkg::REG_KEY_HIGH:   cfg.key_high = value[55:0];
            bfrc_pkg::REG_KEY_LENGTH: cfg.key_length = value[3:0];
            bfrc_pkg::REG_TIME_FLOOR: cfg.time_floor = value[31:0];
            bfrc_pkg::REG_COOLDOWN:   cfg.cooldown_ms = value[31:0];
            default: ;
        endcase
    endtask

    function automatic void random_body(input int n, output t_octets body);
        body = {};
        repeat (n) body.push_back(8'($urandom));
    endfunction

    // magic, fletcher check, then body; check and body keyed as they go on the link
    function automatic void seal_frame(input logic [15:0] magic, input t_octets body,
                                       output t_octets f);
        int      lo;
        int      hi;
        int      kl;
        t_octets plain;
        lo = 0;
        hi = 0;
        kl = cfg.key_length;
        foreach (body[i]) begin
            lo = (lo + body[i]) % 255;
            hi = (hi + lo) % 255;
        end
        plain = {magic[15:8], magic[7:0], 8'(hi), 8'(lo)};
        foreach (body[i]) plain.push_back(body[i]);
        f = {};
        foreach (plain[i]) begin
            if (i >= bfrc_pkg::MAGIC_BYTES && i < bfrc_pkg::MAX_FRAME_BYTES_DEF && kl != 0)
                f.push_back(plain[i] ^ key_at((i - bfrc_pkg::MAGIC_BYTES) % kl));
            else
                f.push_back(plain[i]);
        end
    endfunction

    function automatic void beacon_frame(input logic [31:0] tval, output t_octets f);
        t_octets body;
        body = {tval[31:24], tval[23:16], tval[15:8], tval[7:0]};
        seal_frame(bfrc_pkg::TIME_MAGIC, body, f);
    endfunction

    function automatic logic [31:0] pick_beacon_time();
        case ($urandom_range(0, 4))
            0:       return cfg.time_floor;
            1:       return cfg.time_floor - 1;
            2:       return '1;
            3:       return cfg.time_floor + $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] next_now();
        case ($urandom_range(0, 3))
            0:       wall_ms = wall_ms + $urandom_range(0, 5000);
            1:       wall_ms = last_applied + cfg.cooldown_ms - $urandom_range(0, 1);
            2:       wall_ms = wall_ms + cfg.cooldown_ms;
            default: wall_ms = $urandom;
        endcase
        return wall_ms;
    endfunction

    task automatic randomize_settings();
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [3:0]  len;
        logic [31:0] floor_v;
        logic [31:0] cool_v;
        case ($urandom_range(0, 3))
            0:       key_lo = '0;
            1:       key_lo = '1;
            default: key_lo = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 3))
            0:       key_hi = '0;
            1:       key_hi = '1;
            default: key_hi = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 6))
            0:       len = 4'd0;
            1:       len = 4'd1;
            2:       len = 4'd15;
            default: len = 4'($urandom_range(1, 14));
        endcase
        case ($urandom_range(0, 4))
            0:       floor_v = '0;
            1:       floor_v = bfrc_pkg::TIME_FLOOR_RST;
            2:       floor_v = '1;
            default: floor_v = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       cool_v = '0;
            1:       cool_v = bfrc_pkg::COOLDOWN_RST;
            2:       cool_v = '1;
            3:       cool_v = $urandom_range(1, 5000);
            default: cool_v = $urandom;
        endcase
        write_reg(bfrc_pkg::REG_KEY_LOW, key_lo);
        write_reg(bfrc_pkg::REG_KEY_HIGH, key_hi);
        write_reg(bfrc_pkg::REG_KEY_LENGTH, {$urandom, 28'($urandom), len});
        write_reg(bfrc_pkg::REG_TIME_FLOOR, {$urandom, floor_v});
        write_reg(bfrc_pkg::REG_COOLDOWN, {$urandom, cool_v});
    endtask

    // key length still zero from reset
    task automatic test_unconfigured();
        t_octets body;
        t_octets f;
        f = {8'hC0};
        send_frame(f, $urandom);
        f = {8'hC0, 8'h3E, 8'hFF};
        send_frame(f, $urandom);
        random_body(2, body);
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        send_frame(f, $urandom);
        f = {8'h12, 8'h34, 8'h00, 8'hFF, 8'h5A};
        send_frame(f, $urandom);
        beacon_frame(32'hFFFF_FFFF, f);
        send_frame(f, '1);
        beacon_frame(32'h0, f);
        void'(f.pop_back());
        void'(f.pop_back());
        send_frame(f, '0);
    endtask

    task automatic test_packet_frames();
        t_octets body;
        t_octets f;
        write_reg(bfrc_pkg::REG_KEY_LOW, '1);
        write_reg(bfrc_pkg::REG_KEY_HIGH, {8'h00, 56'hFF_FFFF_FFFF_FFFF});
        write_reg(bfrc_pkg::REG_KEY_LENGTH, 64'd15);
        body = {};
        repeat (10) body.push_back(8'hFF);
        repeat (10) body.push_back(8'h00);
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        send_frame(f, $urandom);
        body = {};
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        send_frame(f, $urandom);
        random_body(12, body);
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        f[6] = f[6] ^ 8'h80;
        send_frame(f, $urandom);
        write_reg(bfrc_pkg::REG_KEY_LOW, '0);
        write_reg(bfrc_pkg::REG_KEY_HIGH, '0);
        write_reg(bfrc_pkg::REG_KEY_LENGTH, 64'd1);
        random_body(5, body);
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        send_frame(f, $urandom);
    endtask

    task automatic test_time_beacons();
        t_octets f;
        write_reg(bfrc_pkg::REG_KEY_LOW, {$urandom, $urandom});
        write_reg(bfrc_pkg::REG_KEY_LENGTH, 64'd7);
        write_reg(bfrc_pkg::REG_TIME_FLOOR, 64'(bfrc_pkg::TIME_FLOOR_RST));
        write_reg(bfrc_pkg::REG_COOLDOWN, 64'(bfrc_pkg::COOLDOWN_RST));
        beacon_frame(bfrc_pkg::TIME_FLOOR_RST - 1, f);
        send_frame(f, 32'd1000);
        beacon_frame(bfrc_pkg::TIME_FLOOR_RST, f);
        send_frame(f, 32'd1000);
        beacon_frame(bfrc_pkg::TIME_FLOOR_RST + 5, f);
        send_frame(f, 32'd1000 + bfrc_pkg::COOLDOWN_RST - 1);
        send_frame(f, 32'd1000 + bfrc_pkg::COOLDOWN_RST);
        f.push_back(8'h00);
        send_frame(f, '1);
        beacon_frame(32'hFFFF_FFFF, f);
        f[3] = f[3] ^ 8'h01;
        send_frame(f, '1);
        // elapsed time wraps below zero
        write_reg(bfrc_pkg::REG_TIME_FLOOR, 64'hFFFF_FFFF);
        write_reg(bfrc_pkg::REG_COOLDOWN, 64'd0);
        beacon_frame(32'hFFFF_FFFF, f);
        send_frame(f, 32'd0);
        beacon_frame(32'hFFFF_FFFE, f);
        send_frame(f, 32'd0);
        write_reg(bfrc_pkg::REG_TIME_FLOOR, 64'd0);
        write_reg(bfrc_pkg::REG_COOLDOWN, 64'hFFFF_FFFF);
        beacon_frame(32'h0, f);
        send_frame(f, 32'd5);
        send_frame(f, 32'hFFFF_FFFF);
    endtask

    task automatic test_key_change_mid_frame();
        t_octets body;
        t_octets f;
        write_reg(bfrc_pkg::REG_KEY_LOW, {$urandom, $urandom});
        write_reg(bfrc_pkg::REG_KEY_HIGH, {$urandom, $urandom});
        write_reg(bfrc_pkg::REG_KEY_LENGTH, 64'd15);
        random_body(26, body);
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        for (int i = 0; i < 10; i++) send_byte(f[i], 1'b0, $urandom);
        write_reg(bfrc_pkg::REG_KEY_LENGTH, 64'd3);
        for (int i = 10; i < f.size(); i++) send_byte(f[i], i == f.size() - 1, $urandom);
    endtask

    task automatic test_backpressure();
        t_octets body;
        t_octets f;
        write_reg(bfrc_pkg::REG_KEY_LENGTH, 64'd5);
        random_body(40, body);
        seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
        hold_req = 150;
        send_frame(f, $urandom);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          next_cfg_at;
        int          kind;
        int          len;
        int          idx;
        t_octets     body;
        t_octets     f;
        sent = 0;
        next_cfg_at = 0;
        while (sent < RANDOM_BYTES) begin
            if (sent >= next_cfg_at) begin
                randomize_settings();
                next_cfg_at = sent + $urandom_range(80, 200);
                src_idle_en = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (sent >= QUIET_AFTER) begin
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
                random_body(len, body);
                seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
            end else if (kind < 65) begin
                beacon_frame(pick_beacon_time(), f);
            end else if (kind < 80) begin
                // damaged frame: one bit flipped after the magic
                if (kind < 72) begin
                    random_body($urandom_range(0, 16), body);
                    seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
                end else begin
                    beacon_frame(pick_beacon_time(), f);
                end
                idx = $urandom_range(bfrc_pkg::MAGIC_BYTES, f.size() - 1);
                f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
            end else if (kind < 88) begin
                random_body($urandom_range(1, 12), f);
            end else if (kind < 93) begin
                len = $urandom_range(0, 7);
                if (len >= 4) len++;
                random_body(len, body);
                seal_frame(bfrc_pkg::TIME_MAGIC, body, f);
            end else if (kind < 96) begin
                random_body(bfrc_pkg::MAX_FRAME_BYTES_DEF - bfrc_pkg::HEAD_BYTES, body);
                seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
            end else begin
                random_body($urandom_range(
                    bfrc_pkg::MAX_FRAME_BYTES_DEF - bfrc_pkg::HEAD_BYTES + 1,
                    bfrc_pkg::MAX_FRAME_BYTES_DEF - bfrc_pkg::HEAD_BYTES + 8), body);
                seal_frame(bfrc_pkg::PACKET_MAGIC, body, f);
            end
            send_frame(f, next_now());
            sent += f.size();
        end
    endtask

    initial begin
        errors = 0;
        hold_req = 0;
        wall_ms = '0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        cfg = '{64'h0, 56'h0, 4'h0, bfrc_pkg::TIME_FLOOR_RST, bfrc_pkg::COOLDOWN_RST};
        clear_frame();
        last_applied = '0;
        applied_once = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_rx_byte <= '0;
        i_frame_last <= 1'b0;
        i_now_ms <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unconfigured();
        test_packet_frames();
        test_time_beacons();
        test_key_change_mid_frame();
        test_backpressure();
        test_random_traffic();

        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("** bridge_frame_receive_checker: PASSED **");
        end else begin
            $display("** bridge_frame_receive_checker: FAILED **");
        end
        $finish;
    end

endmodule
